// File: rtl/drc_pkg.sv
// shared types and constants for the directed reachability counter
`default_nettype none

package drc_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // widths of the word fields
    localparam int NODE_W  = 5;
    localparam int COUNT_W = 5;

    // largest count the result field can carry
    localparam logic [COUNT_W-1:0] MAX_COUNT = 5'd31;

    // control state of the sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    // control bits that travel with the wave around the ring
    typedef struct packed {
        logic vld;
        logic chg;
    } t_wave_ctl;

endpackage

`default_nettype wire

// File: rtl/drc_cell.sv
// one ring cell: holds one adjacency row and expands the passing wave by it
`default_nettype none

module drc_cell
    import drc_pkg::*;
#(
    parameter int NODES = 32,
    parameter int CW    = 6,
    parameter int IDX   = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [NODES-1:0] i_wr_bit,
    input  wire logic             i_clr,
    input  wire logic [NODES-1:0] i_vec,
    input  wire logic [CW-1:0]    i_cnt,
    input  wire t_wave_ctl        i_ctl,
    output logic      [NODES-1:0] o_vec,
    output logic      [CW-1:0]    o_cnt,
    output t_wave_ctl             o_ctl
);

    logic [NODES-1:0] r_row;
    logic [NODES-1:0] r_vec;
    logic [CW-1:0]    r_cnt;
    t_wave_ctl        r_ctl;

    logic [NODES-1:0] n_vec;
    logic [CW-1:0]    n_cnt;
    t_wave_ctl        n_ctl;

    // a marked node pulls in its successors
    always_comb begin
        n_vec     = i_vec | (i_vec[IDX] ? r_row : '0);
        n_cnt     = i_cnt + CW'(n_vec[IDX]);
        n_ctl.vld = i_ctl.vld;
        n_ctl.chg = i_ctl.chg | (n_vec != i_vec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_ctl <= '0;
        end else begin
            if (i_clr) begin
                r_row <= '0;
            end else if (i_wr_en) begin
                r_row <= r_row | i_wr_bit;
            end
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
        r_cnt <= n_cnt;
    end

    assign o_vec = r_vec;
    assign o_cnt = r_cnt;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// File: rtl/directed_reachability_count.sv
// top level: directed graph reachability counter built as a ring of row cells
//
// input channel: i_valid / o_stall carry one word of i_op, i_from_node, i_to_node.
//   add (op 0) sets edge from_node -> to_node, clear (op 2) empties the graph,
//   query (op 1) asks how many nodes are reachable from from_node, start excluded.
//   op 3 and adds naming a node outside the graph are taken and dropped.
// output channel: o_valid / i_stall carry o_reached_count, one word per query.
// add, clear and op 3 leave the sequencer idle.  a query injects a wave
//   into a ring of NODES cells; each cell owns one adjacency row and ORs it into
//   the wave when its node is marked.  the wave laps until a lap marks nothing
//   new, at most NODES laps (the laps that mark a new node plus the final,
//   unchanged one).  the answer word's count is summed by the cells during
//   that final, unchanged lap.
// o_stall is high while a query is in the ring or its word waits to enter the
//   output register; a word already in the output register does not block adds.
// receiver stall: the output word holds until taken; a finished query waits.
// reset (synchronous, i_rst_n low) empties the graph and drops any query.
`default_nettype none

module directed_reachability_count
    import drc_pkg::*;
#(
    parameter int NODES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic [NODE_W-1:0]  i_from_node,
    input  wire logic [NODE_W-1:0]  i_to_node,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [COUNT_W-1:0]      o_reached_count
);

    localparam int CW = $clog2(NODES + 1);

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_res;
    logic [COUNT_W-1:0]   n_res;
    logic                 r_out_vld;
    logic [COUNT_W-1:0]   r_out_cnt;

    // ring wires: output of each cell
    logic [NODES-1:0]     ring_vec [NODES];
    logic [CW-1:0]        ring_cnt [NODES];
    t_wave_ctl            ring_ctl [NODES];

    // head of ring input
    logic [NODES-1:0]     head_vec;
    logic [CW-1:0]        head_cnt;
    t_wave_ctl            head_ctl;

    logic                 accept;
    logic                 from_ok;
    logic                 to_ok;
    logic                 do_add;
    logic                 do_clr;
    logic                 inject;
    logic                 q_bad;
    logic                 done;
    logic                 load_out;
    logic [NODES-1:0]     from_bit;
    logic [NODES-1:0]     to_bit;
    logic [COUNT_W-1:0]   sat_cnt;
    t_wave_ctl            tail_ctl;

    assign accept   = i_valid && !o_stall;
    assign from_ok  = 32'(i_from_node) < NODES;
    assign to_ok    = 32'(i_to_node) < NODES;
    assign from_bit = {{(NODES-1){1'b0}}, 1'b1} << i_from_node;
    assign to_bit   = {{(NODES-1){1'b0}}, 1'b1} << i_to_node;

    assign do_add   = accept && (i_op == OP_ADD) && from_ok && to_ok;
    assign do_clr   = accept && (i_op == OP_CLEAR);
    assign tail_ctl = ring_ctl[NODES-1];

    // wave finished when a full lap marked nothing new
    assign done     = (r_state == S_RUN) && tail_ctl.vld && !tail_ctl.chg;

    // saturated count, start node removed
    always_comb begin
        if (32'(ring_cnt[NODES-1]) > 32'(MAX_COUNT) + 32'd1) begin
            sat_cnt = MAX_COUNT;
        end else begin
            sat_cnt = COUNT_W'(32'(ring_cnt[NODES-1]) - 32'd1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_QUERY)) begin
                    n_state = from_ok ? S_RUN : S_HOLD;
                end
            end
            S_RUN: begin
                if (done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_vld || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        inject   = 1'b0;
        q_bad    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                inject  = accept && (i_op == OP_QUERY) && from_ok;
                q_bad   = accept && (i_op == OP_QUERY) && !from_ok;
            end
            S_RUN: begin
                o_stall = 1'b1;
            end
            S_HOLD: begin
                load_out = !r_out_vld || !i_stall;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // held result
    always_comb begin
        n_res = r_res;
        if (q_bad) begin
            n_res = '0;
        end else if (done) begin
            n_res = sat_cnt;
        end
    end

    // ring head: fresh wave or the previous lap coming round
    always_comb begin
        head_vec     = inject ? from_bit : ring_vec[NODES-1];
        head_cnt     = '0;
        head_ctl.vld = inject || (tail_ctl.vld && tail_ctl.chg);
        head_ctl.chg = 1'b0;
    end

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        logic [NODES-1:0] c_vec;
        logic [CW-1:0]    c_cnt;
        t_wave_ctl        c_ctl;
        logic             c_wr;

        assign c_wr = do_add && (32'(i_from_node) == g);

        if (g == 0) begin : g_head
            assign c_vec = head_vec;
            assign c_cnt = head_cnt;
            assign c_ctl = head_ctl;
        end else begin : g_link
            assign c_vec = ring_vec[g-1];
            assign c_cnt = ring_cnt[g-1];
            assign c_ctl = ring_ctl[g-1];
        end

        drc_cell #(
            .NODES (NODES),
            .CW    (CW),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (c_wr),
            .i_wr_bit (to_bit),
            .i_clr    (do_clr),
            .i_vec    (c_vec),
            .i_cnt    (c_cnt),
            .i_ctl    (c_ctl),
            .o_vec    (ring_vec[g]),
            .o_cnt    (ring_cnt[g]),
            .o_ctl    (ring_ctl[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load_out) begin
            r_out_cnt <= r_res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_reached_count = r_out_cnt;

endmodule

`default_nettype wire
